[hw/rtl/hng_pkg.sv]
// hng_pkg: shared constants, register codes and pipeline records
// of the height map normal generator
// no dependencies
package hng_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int DIM_W     = 11;

  // square root: one result bit per step
  localparam int SQRT_STEPS     = 16;
  localparam int SQRT_PER_STAGE = 2;
  localparam int SQRT_STAGES    = SQRT_STEPS / SQRT_PER_STAGE;

  // restoring divider: one quotient bit per step
  localparam int DIV_STEPS     = 16;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;

  typedef enum logic [2:0] {
    REG_MAP_WIDTH   = 3'd0,
    REG_MAP_ROWS    = 3'd1,
    REG_HEIGHT_GAIN = 3'd2,
    REG_COLUMN_STEP = 3'd3,
    REG_ROW_STEP    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] gain;
    logic [15:0] col_step;
    logic [15:0] row_step;
  } cfg_t;

  // stage 1: neighbour samples of one pixel
  typedef struct packed {
    logic             valid;
    logic [7:0]       mid_c;
    logic [7:0]       mid_cmax;
    logic [7:0]       mid_cmin;
    logic [7:0]       smin;
    logic [7:0]       smax;
    logic [1:0]       run_a;
    logic [1:0]       run_b;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } pix_t;

  // fields that ride along to the output
  typedef struct packed {
    logic [25:0]      pos_x;
    logic [15:0]      pos_y;
    logic [25:0]      pos_z;
    logic [COL_W-1:0] tex_u;
    logic [ROW_W-1:0] tex_v;
    logic             last;
  } side_t;

  typedef struct packed {
    logic [15:0] mag;
    logic        neg;
    logic [1:0]  run;
  } axis_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    axis_t       a;
    axis_t       b;
    logic [31:0] sq_a;
    logic [31:0] sq_b;
  } slope_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    axis_t       a;
    axis_t       b;
    logic [15:0] ra;
    logic [15:0] rb;
  } root_t;

  typedef struct packed {
    logic        valid;
    side_t       side;
    logic [15:0] nx;
    logic [14:0] ny;
    logic [15:0] nz;
  } res_t;

endpackage

[hw/rtl/hng_front.sv]
// hng_front: configuration registers, raster counters, the two row stores
// and the first pipeline stage that picks each pixel's neighbours
// depends on hng_pkg
module hng_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    accept,
  input  logic                    kind,
  input  logic [7:0]              sample,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  output hng_pkg::cfg_t           cfg,
  output hng_pkg::pix_t           pix
);

  localparam int CW = hng_pkg::COL_W;
  localparam int DW = hng_pkg::DIM_W;
  localparam int RW = hng_pkg::ROW_W;

  logic [DW-1:0] width_r, rows_r;
  logic [15:0]   gain_r, cstep_r, rstep_r;

  logic [CW-1:0] col_r;
  logic [DW-1:0] row_r, drain_r;
  logic          sel_r;

  logic [7:0] mem_a [hng_pkg::MAX_WIDTH];
  logic [7:0] mem_b [hng_pkg::MAX_WIDTH];
  logic [7:0] a_c_r, a_x_r, b_c_r, b_x_r;

  logic          v1_r, sel1_r, flush1_r, c0_r, p01_r, last1_r;
  logic [7:0]    smp1_r, prev_r;
  logic [1:0]    ka1_r, kb1_r;
  logic [CW-1:0] c1_r;
  logic [RW-1:0] p1_r;

  logic [DW-1:0] w_eff, rows_eff, c_inc, p_full;
  logic [CW-1:0] c_sel, cmax;
  logic          in_map, do_sample, do_drain, emit, col_end, p0;
  logic [1:0]    ka, kb;
  logic [7:0]    other_c, other_x, cur_c;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= DW'(1);
      rows_r  <= DW'(1);
      gain_r  <= 16'd256;
      cstep_r <= 16'd256;
      rstep_r <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        hng_pkg::REG_MAP_WIDTH:   width_r <= cfg_data[DW-1:0];
        hng_pkg::REG_MAP_ROWS:    rows_r  <= cfg_data[DW-1:0];
        hng_pkg::REG_HEIGHT_GAIN: gain_r  <= cfg_data;
        hng_pkg::REG_COLUMN_STEP: cstep_r <= cfg_data;
        hng_pkg::REG_ROW_STEP:    rstep_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.gain     = gain_r;
  assign cfg.col_step = cstep_r;
  assign cfg.row_step = rstep_r;

  // decode of the incoming transaction
  always_comb begin
    if (width_r == '0) w_eff = DW'(1);
    else if (width_r > DW'(hng_pkg::MAX_WIDTH)) w_eff = DW'(hng_pkg::MAX_WIDTH);
    else w_eff = width_r;
    if (rows_r == '0) rows_eff = DW'(1);
    else if (rows_r > DW'(hng_pkg::MAX_ROWS)) rows_eff = DW'(hng_pkg::MAX_ROWS);
    else rows_eff = rows_r;

    in_map    = row_r < rows_eff;
    do_sample = accept && !kind && in_map;
    do_drain  = accept && kind && !in_map && (drain_r < w_eff);
    emit      = (do_sample && (row_r != '0)) || do_drain;

    c_sel   = kind ? drain_r[CW-1:0] : col_r;
    c_inc   = {{(DW-CW){1'b0}}, c_sel} + DW'(1);
    col_end = c_inc >= w_eff;
    cmax    = col_end ? c_sel : c_inc[CW-1:0];
    p_full  = row_r - DW'(1);
    p0      = row_r == DW'(1);

    ka = 2'(c_sel != '0) + 2'(!col_end);
    if (kind) kb = p0 ? 2'd0 : 2'd1;
    else kb = p0 ? 2'd1 : 2'd2;
  end

  // raster position, store select and drain pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      drain_r <= '0;
      sel_r   <= 1'b0;
    end else if (do_sample) begin
      drain_r <= '0;
      if (col_end) begin
        col_r <= '0;
        row_r <= row_r + DW'(1);
        sel_r <= !sel_r;
      end else begin
        col_r <= c_inc[CW-1:0];
      end
    end else if (do_drain) begin
      drain_r <= drain_r + DW'(1);
    end
  end

  // row stores: registered reads at the column and its right neighbour
  always_ff @(posedge clk) begin
    if (en) begin
      a_c_r <= mem_a[c_sel];
      a_x_r <= mem_a[cmax];
      b_c_r <= mem_b[c_sel];
      b_x_r <= mem_b[cmax];
    end
    if (do_sample && !sel_r) mem_a[col_r] <= sample;
    if (do_sample && sel_r) mem_b[col_r] <= sample;
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel1_r   <= sel_r;
      flush1_r <= kind;
      smp1_r   <= sample;
      c0_r     <= c_sel == '0;
      p01_r    <= p0;
      ka1_r    <= ka;
      kb1_r    <= kb;
      c1_r     <= c_sel;
      p1_r     <= p_full[RW-1:0];
      last1_r  <= kind && col_end;
    end
    // left neighbour is the previous pixel's own sample
    if (en && v1_r) prev_r <= other_c;
  end

  // neighbour selection
  always_comb begin
    other_c = sel1_r ? a_c_r : b_c_r;
    other_x = sel1_r ? a_x_r : b_x_r;
    cur_c   = sel1_r ? b_c_r : a_c_r;

    pix.valid    = v1_r;
    pix.mid_c    = other_c;
    pix.mid_cmax = other_x;
    pix.mid_cmin = c0_r ? other_c : prev_r;
    pix.smin     = p01_r ? other_c : cur_c;
    pix.smax     = flush1_r ? other_c : smp1_r;
    pix.run_a    = ka1_r;
    pix.run_b    = kb1_r;
    pix.col      = c1_r;
    pix.row      = p1_r;
    pix.last     = last1_r;
  end

`ifndef NO_ASSERTIONS
  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_drain |=> drain_r == $past(drain_r) + DW'(1))
    else $error("drain pointer did not advance after a drain transaction");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (do_sample && col_end) |=> (col_r == '0) && (sel_r != $past(sel_r)))
    else $error("row end did not wrap the column and swap stores");

  a_emit_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (en && emit) |=> v1_r)
    else $error("emitting transaction missing from stage 1");
`endif

endmodule

[hw/rtl/hng_lift.sv]
// hng_lift: heights, positions, height differences and their squares
// (pipeline stages 2 and 3)
// depends on hng_pkg
module hng_lift (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  hng_pkg::cfg_t   cfg,
  input  hng_pkg::pix_t   pix,
  output hng_pkg::slope_t slope
);

  localparam int CW = hng_pkg::COL_W;
  localparam int RW = hng_pkg::ROW_W;

  logic          v2_r;
  logic [15:0]   h_cmax_r, h_cmin_r, h_smax_r, h_smin_r, h_mid_r;
  logic [25:0]   px_r, pz_r;
  logic [1:0]    ka2_r, kb2_r;
  logic [CW-1:0] c2_r;
  logic [RW-1:0] p2_r;
  logic          last2_r;

  logic [16:0]   da, db;
  logic [15:0]   ma, mb;

  hng_pkg::slope_t slope_r;

  function automatic logic [15:0] lift(input logic [7:0] s, input logic [15:0] g);
    logic [23:0] prod;
    prod = {16'b0, s} * {8'b0, g};
    return prod[23:8];
  endfunction

  // stage 2: Q8.8 heights and positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_cmax_r <= lift(pix.mid_cmax, cfg.gain);
      h_cmin_r <= lift(pix.mid_cmin, cfg.gain);
      h_smax_r <= lift(pix.smax, cfg.gain);
      h_smin_r <= lift(pix.smin, cfg.gain);
      h_mid_r  <= lift(pix.mid_c, cfg.gain);
      px_r     <= 26'(pix.col) * 26'(cfg.col_step);
      pz_r     <= 26'(pix.row) * 26'(cfg.row_step);
      ka2_r    <= pix.run_a;
      kb2_r    <= pix.run_b;
      c2_r     <= pix.col;
      p2_r     <= pix.row;
      last2_r  <= pix.last;
    end
  end

  // stage 3: magnitudes and squares of the differences
  always_comb begin
    da = {1'b0, h_cmax_r} - {1'b0, h_cmin_r};
    db = {1'b0, h_smax_r} - {1'b0, h_smin_r};
    ma = da[16] ? 16'(-da) : da[15:0];
    mb = db[16] ? 16'(-db) : db[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slope_r.valid <= 1'b0;
    end else if (en) begin
      slope_r.valid <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      slope_r.side.pos_x <= px_r;
      slope_r.side.pos_y <= h_mid_r;
      slope_r.side.pos_z <= pz_r;
      slope_r.side.tex_u <= c2_r;
      slope_r.side.tex_v <= p2_r;
      slope_r.side.last  <= last2_r;
      slope_r.a.mag      <= ma;
      slope_r.a.neg      <= da[16];
      slope_r.a.run      <= ka2_r;
      slope_r.b.mag      <= mb;
      slope_r.b.neg      <= db[16];
      slope_r.b.run      <= kb2_r;
      slope_r.sq_a       <= {16'b0, ma} * {16'b0, ma};
      slope_r.sq_b       <= {16'b0, mb} * {16'b0, mb};
    end
  end

  assign slope = slope_r;

endmodule

[hw/rtl/hng_sqrt.sv]
// hng_sqrt: pipelined floor square root of d^2 + run^2 for both slopes,
// two result bits per stage
// depends on hng_pkg
module hng_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  hng_pkg::slope_t slope,
  output hng_pkg::root_t  root
);

  localparam int NS = hng_pkg::SQRT_STAGES;

  typedef struct packed {
    logic [31:0] rad;
    logic [17:0] rem;
    logic [15:0] res;
  } lane_t;

  typedef struct packed {
    logic           valid;
    hng_pkg::side_t side;
    hng_pkg::axis_t a;
    hng_pkg::axis_t b;
    lane_t          la;
    lane_t          lb;
  } stg_t;

  stg_t stg_r   [NS];
  stg_t stg_nxt [NS];

  function automatic lane_t seed(input logic [31:0] sq, input logic [1:0] run);
    lane_t o;
    logic [2:0] rr;
    rr    = {1'b0, run} * {1'b0, run};
    o.rad = sq + {13'b0, rr, 16'b0};
    o.rem = '0;
    o.res = '0;
    return o;
  endfunction

  // one digit pair of the radicand per step
  function automatic lane_t step(input lane_t l);
    lane_t o;
    logic [19:0] r2, tr;
    r2    = {l.rem, l.rad[31:30]};
    tr    = {2'b00, l.res, 2'b01};
    o.rad = {l.rad[29:0], 2'b00};
    if (r2 >= tr) begin
      o.rem = 18'(r2 - tr);
      o.res = {l.res[14:0], 1'b1};
    end else begin
      o.rem = r2[17:0];
      o.res = {l.res[14:0], 1'b0};
    end
    return o;
  endfunction

  always_comb begin
    stg_t cur;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        cur.valid = slope.valid;
        cur.side  = slope.side;
        cur.a     = slope.a;
        cur.b     = slope.b;
        cur.la    = seed(slope.sq_a, slope.a.run);
        cur.lb    = seed(slope.sq_b, slope.b.run);
      end else begin
        cur = stg_r[k-1];
      end
      for (int j = 0; j < hng_pkg::SQRT_PER_STAGE; j++) begin
        cur.la = step(cur.la);
        cur.lb = step(cur.lb);
      end
      stg_nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        stg_r[k].valid <= 1'b0;
      end else if (en) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign root.valid = stg_r[NS-1].valid;
  assign root.side  = stg_r[NS-1].side;
  assign root.a     = stg_r[NS-1].a;
  assign root.b     = stg_r[NS-1].b;
  assign root.ra    = stg_r[NS-1].la.res;
  assign root.rb    = stg_r[NS-1].lb.res;

endmodule

[hw/rtl/hng_div.sv]
// hng_div: operand set-up, three pipelined restoring dividers and the
// rounding, saturation and sign of the Q1.15 normal
// depends on hng_pkg
module hng_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  hng_pkg::root_t root,
  output hng_pkg::res_t  res
);

  localparam int NS = hng_pkg::DIV_STAGES;

  typedef struct packed {
    logic [15:0] lo;
    logic [32:0] rem;
    logic [31:0] den;
    logic [15:0] q;
  } lane_t;

  typedef struct packed {
    logic           valid;
    hng_pkg::side_t side;
    logic           neg_a;
    logic           neg_b;
    logic           zero_a;
    logic           zero_b;
    logic [31:0]    nx;
    logic [31:0]    nz;
    logic [15:0]    ra;
    logic [15:0]    rb;
    logic [18:0]    ab;
    logic [31:0]    den;
  } prep_t;

  typedef struct packed {
    logic           valid;
    hng_pkg::side_t side;
    logic           neg_a;
    logic           neg_b;
    logic           zero_a;
    logic           zero_b;
    lane_t          lx;
    lane_t          ly;
    lane_t          lz;
  } stg_t;

  prep_t prep_r, prep_nxt;
  stg_t  stg_r   [NS];
  stg_t  stg_nxt [NS];

  logic [15:0] fa, fb;
  logic [9:0]  ca, cb;
  logic [19:0] abp;
  logic [14:0] mag_x, mag_y, mag_z;

  function automatic lane_t seed(input logic [33:0] n, input logic [31:0] d);
    lane_t o;
    o.lo  = n[15:0];
    o.rem = {15'b0, n[33:16]};
    o.den = d;
    o.q   = '0;
    return o;
  endfunction

  function automatic lane_t step(input lane_t l);
    lane_t o;
    logic [32:0] r2;
    r2    = {l.rem[31:0], l.lo[15]};
    o.lo  = {l.lo[14:0], 1'b0};
    o.den = l.den;
    if (r2 >= {1'b0, l.den}) begin
      o.rem = r2 - {1'b0, l.den};
      o.q   = {l.q[14:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q   = {l.q[14:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [14:0] sat(input logic [15:0] q);
    return q[15] ? 15'h7fff : q[14:0];
  endfunction

  // set-up: sine numerators with half-divisor rounding, cosine product terms
  always_comb begin
    fa = (root.ra == '0) ? 16'd1 : root.ra;
    fb = (root.rb == '0) ? 16'd1 : root.rb;
    ca = (root.ra == '0) ? 10'd1 : {root.a.run, 8'b0};
    cb = (root.rb == '0) ? 10'd1 : {root.b.run, 8'b0};
    abp = ca * cb;

    prep_nxt.valid  = root.valid;
    prep_nxt.side   = root.side;
    prep_nxt.neg_a  = root.a.neg;
    prep_nxt.neg_b  = root.b.neg;
    prep_nxt.zero_a = root.ra == '0;
    prep_nxt.zero_b = root.rb == '0;
    prep_nxt.nx     = {1'b0, root.a.mag, 15'b0} + {17'b0, root.ra[15:1]};
    prep_nxt.nz     = {1'b0, root.b.mag, 15'b0} + {17'b0, root.rb[15:1]};
    prep_nxt.ra     = root.ra;
    prep_nxt.rb     = root.rb;
    prep_nxt.ab     = abp[18:0];
    prep_nxt.den    = {16'b0, fa} * {16'b0, fb};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else if (en) begin
      prep_r <= prep_nxt;
    end
  end

  // divider stages
  always_comb begin
    stg_t cur;
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        cur.valid  = prep_r.valid;
        cur.side   = prep_r.side;
        cur.neg_a  = prep_r.neg_a;
        cur.neg_b  = prep_r.neg_b;
        cur.zero_a = prep_r.zero_a;
        cur.zero_b = prep_r.zero_b;
        cur.lx     = seed({2'b0, prep_r.nx}, {16'b0, prep_r.ra});
        cur.lz     = seed({2'b0, prep_r.nz}, {16'b0, prep_r.rb});
        cur.ly     = seed({prep_r.ab, 15'b0} + {3'b0, prep_r.den[31:1]}, prep_r.den);
      end else begin
        cur = stg_r[k-1];
      end
      for (int j = 0; j < hng_pkg::DIV_PER_STAGE; j++) begin
        cur.lx = step(cur.lx);
        cur.ly = step(cur.ly);
        cur.lz = step(cur.lz);
      end
      stg_nxt[k] = cur;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (!rst_n) begin
        stg_r[k].valid <= 1'b0;
      end else if (en) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  // saturation and sign: a falling slope gives a positive component
  always_comb begin
    mag_x = sat(stg_r[NS-1].lx.q);
    mag_y = sat(stg_r[NS-1].ly.q);
    mag_z = sat(stg_r[NS-1].lz.q);

    res.valid = stg_r[NS-1].valid;
    res.side  = stg_r[NS-1].side;
    res.ny    = mag_y;
    if (stg_r[NS-1].zero_a) res.nx = '0;
    else if (stg_r[NS-1].neg_a) res.nx = {1'b0, mag_x};
    else res.nx = 16'(-{1'b0, mag_x});
    if (stg_r[NS-1].zero_b) res.nz = '0;
    else if (stg_r[NS-1].neg_b) res.nz = {1'b0, mag_z};
    else res.nz = 16'(-{1'b0, mag_z});
  end

endmodule

[hw/rtl/heightmap_normal_generator.sv]
// heightmap_normal_generator: top level, height samples in raster order
// to vertex records with central-difference normals
// depends on hng_pkg, hng_front, hng_lift, hng_sqrt, hng_div
//
// channel  direction  handshake           payload
// in_      slave      tvalid/tready       tuser kind, tdata sample
// out_     master     tvalid/tready       tdata vertex record, tlast last vertex
// cfg_     write      we, one cycle       index selects register, data value
//
// One transaction enters per clock while the output buffer has room; the
// sample that releases a result passes through the row store read, two
// height/slope stages, eight square root stages, one set-up stage, eight
// divider stages and the output buffer.
// Synchronous active-low reset clears control only; row stores are not
// cleared and need no clearing pass.
// A two-entry output buffer takes results; the whole pipeline holds while
// that buffer is full, so in_tready drops only when two results wait.
module heightmap_normal_generator (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] sample
  input  logic         in_tuser,   // [0] kind
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [167:0] out_tdata,  // pos_x, pos_y, pos_z, tex_u, tex_v, normal_x,
                                   // normal_y, normal_z, tangent_x, tangent_y
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  hng_pkg::cfg_t   cfg;
  hng_pkg::pix_t   pix;
  hng_pkg::slope_t slope;
  hng_pkg::root_t  root;
  hng_pkg::res_t   res;
  hng_pkg::res_t   head;

  hng_pkg::res_t fifo_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          en, accept, push, pop;

  // pipeline moves while the output buffer has room
  assign en        = cnt_r != 2'd2;
  assign in_tready = en;
  assign accept    = in_tvalid && en;
  assign push      = en && res.valid;
  assign pop       = out_tvalid && out_tready;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  hng_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .accept    (accept),
    .kind      (in_tuser),
    .sample    (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .pix       (pix)
  );

  hng_lift u_lift (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cfg   (cfg),
    .pix   (pix),
    .slope (slope)
  );

  hng_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .slope (slope),
    .root  (root)
  );

  hng_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .root  (root),
    .res   (res)
  );

  // output buffer pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) fifo_r[wp_r] <= res;
  end

  // result transaction
  assign head       = fifo_r[rp_r];
  assign out_tvalid = cnt_r != 2'd0;
  assign out_tlast  = head.side.last;
  assign out_tdata  = {2'b00,
                       16'(-head.nx),
                       head.ny,
                       head.nz,
                       head.ny,
                       head.nx,
                       head.side.tex_v,
                       head.side.tex_u,
                       head.side.pos_z,
                       head.side.pos_y,
                       head.side.pos_x};

endmodule
